// ----- rtl/core/qpt_pkg.sv -----
// Shared types, constants and the quadrature transition table for the
// pitch tuner core. No dependencies; every other file in rtl/core imports it.
`default_nettype none
package qpt_pkg;

	localparam int unsigned DEBOUNCE_MS_DEF = 5;
	localparam int unsigned DETENT_DEF      = 2;

	localparam int OFS_W      = 16;
	localparam int FREQ_W     = 28;
	localparam int STEP_W     = 14;
	localparam int TIME_W     = 32;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 28;

	typedef logic signed [1:0]        dir_t;
	typedef logic signed [OFS_W-1:0]  ofs_t;
	typedef logic [FREQ_W-1:0]        freq_t;
	typedef logic [STEP_W-1:0]        step_t;
	typedef logic [TIME_W-1:0]        time_t;

	localparam dir_t DIR_NONE = 2'b00;
	localparam dir_t DIR_UP   = 2'b01;
	localparam dir_t DIR_DOWN = 2'b11;

	typedef enum logic [1:0] {
		MODE_LOWER = 2'd0,
		MODE_UPPER = 2'd1,
		MODE_CW    = 2'd2,
		MODE_KEEP  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE    = 4'd0,
		REG_MODE      = 4'd1,
		REG_STEP      = 4'd2,
		REG_PITCH_MIN = 4'd3,
		REG_PITCH_MAX = 4'd4,
		REG_LSB_BASE  = 4'd5,
		REG_USB_BASE  = 4'd6,
		REG_CW_BASE   = 4'd7
	} reg_idx_t;

	localparam step_t STEP_RST      = 14'd10;
	localparam ofs_t  PITCH_MIN_RST = -16'sd1000;
	localparam ofs_t  PITCH_MAX_RST = 16'sd1000;
	localparam freq_t LSB_BASE_RST  = 28'd9000000;
	localparam freq_t USB_BASE_RST  = 28'd9003000;
	localparam freq_t CW_BASE_RST   = 28'd9001500;

	// {previous pair, current pair} codes of valid transitions
	localparam logic [3:0] QF_0 = 4'b1101;
	localparam logic [3:0] QF_1 = 4'b0100;
	localparam logic [3:0] QF_2 = 4'b0010;
	localparam logic [3:0] QF_3 = 4'b1011;
	localparam logic [3:0] QB_0 = 4'b1110;
	localparam logic [3:0] QB_1 = 4'b0111;
	localparam logic [3:0] QB_2 = 4'b0001;
	localparam logic [3:0] QB_3 = 4'b1000;

	function automatic dir_t quad_dir(input logic [3:0] code);
		dir_t d;
		unique case (code)
			QF_0, QF_1, QF_2, QF_3: d = DIR_UP;
			QB_0, QB_1, QB_2, QB_3: d = DIR_DOWN;
			default:                d = DIR_NONE;
		endcase
		return d;
	endfunction

	typedef struct packed {
		dir_t dir;
		ofs_t offset;
		logic changed;
	} pitch_word_t;

endpackage
`default_nettype wire

// ----- rtl/core/qpt_decode.sv -----
// Debounce filter and quadrature transition counter for the pitch tuner.
// Depends on qpt_pkg.
`default_nettype none
module qpt_decode #(
	parameter int unsigned DEBOUNCE_MS        = qpt_pkg::DEBOUNCE_MS_DEF,
	parameter int unsigned DETENT_TRANSITIONS = qpt_pkg::DETENT_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         take,
	input  wire logic         enable,
	input  wire logic [1:0]   pair,
	input  wire qpt_pkg::time_t now_ms,
	output qpt_pkg::dir_t     dir
);
	import qpt_pkg::*;

	localparam int CNT_W = (DETENT_TRANSITIONS > 1) ? $clog2(DETENT_TRANSITIONS) : 1;

	logic [1:0]       stable_q;
	logic [1:0]       prior_q;
	logic [CNT_W-1:0] cnt_q;
	time_t            window_q;

	time_t elapsed;
	logic  quiet;
	logic  same;
	dir_t  trans;
	logic  last_one;

	assign elapsed  = now_ms - window_q;
	assign quiet    = elapsed >= TIME_W'(DEBOUNCE_MS);
	assign same     = pair == stable_q;
	assign trans    = quad_dir({prior_q, pair});
	assign last_one = cnt_q == CNT_W'(DETENT_TRANSITIONS - 1);

	assign dir = (enable && quiet && same && trans != DIR_NONE && last_one) ? trans : DIR_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= '0;
			prior_q  <= '0;
			cnt_q    <= '0;
			window_q <= '0;
		end else if (take && enable && quiet) begin
			if (!same) begin
				// pins moved: restart the window on the new pair
				stable_q <= pair;
				window_q <= now_ms;
			end else begin
				if (trans != DIR_NONE) begin
					cnt_q <= last_one ? '0 : cnt_q + 1'b1;
				end
				prior_q <= pair;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/qpt_pitch.sv -----
// Saturating pitch offset accumulator; loads the first pipeline register.
// Depends on qpt_pkg.
`default_nettype none
module qpt_pitch (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire qpt_pkg::dir_t dir,
	input  wire qpt_pkg::step_t step,
	input  wire qpt_pkg::ofs_t pitch_min,
	input  wire qpt_pkg::ofs_t pitch_max,
	output qpt_pkg::pitch_word_t word_s1
);
	import qpt_pkg::*;

	localparam int SUM_W = OFS_W + 2;

	ofs_t offset_q;

	logic signed [SUM_W-1:0] off_x;
	logic signed [SUM_W-1:0] step_x;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] lo_x;
	logic signed [SUM_W-1:0] hi_x;
	logic signed [SUM_W-1:0] clamped;
	logic                    changed;
	ofs_t                    next_off;

	assign off_x  = SUM_W'(offset_q);
	assign step_x = $signed({{(SUM_W-STEP_W){1'b0}}, step});
	assign sum    = (dir == DIR_UP) ? off_x + step_x : off_x - step_x;
	assign lo_x   = SUM_W'(pitch_min);
	assign hi_x   = SUM_W'(pitch_max);

	// low limit first, high limit wins when the two cross
	always_comb begin
		clamped = sum;
		if (clamped < lo_x) begin
			clamped = lo_x;
		end
		if (clamped > hi_x) begin
			clamped = hi_x;
		end
	end

	assign changed  = (dir != DIR_NONE) && (clamped != off_x);
	assign next_off = changed ? clamped[OFS_W-1:0] : offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (take) begin
			offset_q <= next_off;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s1.dir     <= dir;
			word_s1.offset  <= next_off;
			word_s1.changed <= changed;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/qpt_freq.sv -----
// Oscillator frequency stage: base for the sideband plus offset, saturated,
// and the result register. Depends on qpt_pkg.
`default_nettype none
module qpt_freq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire qpt_pkg::pitch_word_t word_s1,
	input  wire qpt_pkg::mode_t      mode,
	input  wire qpt_pkg::freq_t      lsb_base,
	input  wire qpt_pkg::freq_t      usb_base,
	input  wire qpt_pkg::freq_t      cw_base,
	output qpt_pkg::dir_t            step_dir,
	output qpt_pkg::ofs_t            offset_now,
	output qpt_pkg::freq_t           osc_frequency,
	output logic                     freq_changed
);
	import qpt_pkg::*;

	localparam int F_W = FREQ_W + 2;

	freq_t freq_q;
	dir_t  dir_s2;
	ofs_t  offset_s2;
	logic  changed_s2;

	freq_t               base;
	logic                keep;
	logic signed [F_W-1:0] f_sum;
	freq_t               f_sat;

	always_comb begin
		keep = 1'b0;
		unique case (mode)
			MODE_LOWER: base = lsb_base;
			MODE_UPPER: base = usb_base;
			MODE_CW:    base = cw_base;
			MODE_KEEP: begin
				base = lsb_base;
				keep = 1'b1;
			end
			default: begin
				base = lsb_base;
				keep = 1'b1;
			end
		endcase
	end

	assign f_sum = $signed({2'b00, base}) + F_W'(word_s1.offset);

	always_comb begin
		if (f_sum[F_W-1]) begin
			f_sat = '0;
		end else if (f_sum[F_W-2:FREQ_W] != '0) begin
			f_sat = '1;
		end else begin
			f_sat = f_sum[FREQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= '0;
		end else if (load && word_s1.changed && !keep) begin
			freq_q <= f_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dir_s2     <= word_s1.dir;
			offset_s2  <= word_s1.offset;
			changed_s2 <= word_s1.changed;
		end
	end

	assign step_dir      = dir_s2;
	assign offset_now    = offset_s2;
	assign osc_frequency = freq_q;
	assign freq_changed  = changed_s2;

endmodule
`default_nettype wire

// ----- rtl/core/quadrature_pitch_tuner_core.sv -----
// Debounced quadrature encoder pitch tuner. Takes one pin sample per cycle
// while in_ready is high (in_valid/in_ready) and returns one word per sample
// through the stage registers: detent seen, pitch offset and oscillator
// frequency. The rate is one sample per clock without stalls. The first stage
// does debounce, transition count and saturating offset add; the second
// saturates base plus offset into the result register. Configuration is
// written through cfg_we/cfg_index/cfg_data, by the user only while idle
// (not enforced). Depends on qpt_pkg, qpt_decode, qpt_pitch and qpt_freq.
`default_nettype none
module quadrature_pitch_tuner_core #(
	parameter int unsigned DEBOUNCE_MS        = qpt_pkg::DEBOUNCE_MS_DEF,
	parameter int unsigned DETENT_TRANSITIONS = qpt_pkg::DETENT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [qpt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [qpt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          pin_a,
	input  wire logic                          pin_b,
	input  wire qpt_pkg::time_t                now_ms,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output qpt_pkg::dir_t                      step_dir,
	output qpt_pkg::ofs_t                      offset_now,
	output qpt_pkg::freq_t                     osc_frequency,
	output logic                               freq_changed
);
	import qpt_pkg::*;

	logic  enable_q;
	mode_t mode_q;
	step_t step_q;
	ofs_t  pitch_min_q;
	ofs_t  pitch_max_q;
	freq_t lsb_base_q;
	freq_t usb_base_q;
	freq_t cw_base_q;

	logic        valid_s1;
	logic        valid_s2;
	logic        s1_en;
	logic        s2_en;
	logic        take;
	logic        load;
	dir_t        dir;
	pitch_word_t word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			mode_q      <= MODE_LOWER;
			step_q      <= STEP_RST;
			pitch_min_q <= PITCH_MIN_RST;
			pitch_max_q <= PITCH_MAX_RST;
			lsb_base_q  <= LSB_BASE_RST;
			usb_base_q  <= USB_BASE_RST;
			cw_base_q   <= CW_BASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE:    enable_q    <= cfg_data[0];
				REG_MODE:      mode_q      <= mode_t'(cfg_data[1:0]);
				REG_STEP:      step_q      <= cfg_data[STEP_W-1:0];
				REG_PITCH_MIN: pitch_min_q <= cfg_data[OFS_W-1:0];
				REG_PITCH_MAX: pitch_max_q <= cfg_data[OFS_W-1:0];
				REG_LSB_BASE:  lsb_base_q  <= cfg_data[FREQ_W-1:0];
				REG_USB_BASE:  usb_base_q  <= cfg_data[FREQ_W-1:0];
				REG_CW_BASE:   cw_base_q   <= cfg_data[FREQ_W-1:0];
				default: ;
			endcase
		end
	end

	// advance a stage when the one after it is empty or draining
	assign s2_en    = !valid_s2 || out_ready;
	assign s1_en    = !valid_s1 || s2_en;
	assign in_ready = s1_en;
	assign take     = in_valid && s1_en;
	assign load     = valid_s1 && s2_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_en) begin
				valid_s1 <= in_valid;
			end
			if (s2_en) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign out_valid = valid_s2;

	qpt_decode #(
		.DEBOUNCE_MS        (DEBOUNCE_MS),
		.DETENT_TRANSITIONS (DETENT_TRANSITIONS)
	) u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.enable (enable_q),
		.pair   ({pin_a, pin_b}),
		.now_ms (now_ms),
		.dir    (dir)
	);

	qpt_pitch u_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.dir       (dir),
		.step      (step_q),
		.pitch_min (pitch_min_q),
		.pitch_max (pitch_max_q),
		.word_s1   (word_s1)
	);

	qpt_freq u_freq (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.word_s1       (word_s1),
		.mode          (mode_q),
		.lsb_base      (lsb_base_q),
		.usb_base      (usb_base_q),
		.cw_base       (cw_base_q),
		.step_dir      (step_dir),
		.offset_now    (offset_now),
		.osc_frequency (osc_frequency),
		.freq_changed  (freq_changed)
	);

endmodule
`default_nettype wire

// ----- rtl/core/qpt_checker.sv -----
// Port-level checks for the pitch tuner core, bound to the top level.
// Depends on qpt_pkg and quadrature_pitch_tuner_core.
`default_nettype none
module qpt_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire qpt_pkg::dir_t                 step_dir,
	input wire qpt_pkg::ofs_t                 offset_now,
	input wire qpt_pkg::freq_t                osc_frequency,
	input wire logic                          freq_changed
);
	import qpt_pkg::*;

	// an offset change needs a detent behind it
	a_change_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && freq_changed |-> step_dir != DIR_NONE)
		else $error("freq_changed without a detent");

	// the unused code of the signed direction never shows
	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> step_dir != 2'b10)
		else $error("step_dir carries an illegal code");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(offset_now)
			&& $stable(osc_frequency) && $stable(step_dir) && $stable(freq_changed))
		else $error("result word changed while stalled");

	// with the output side stalled and full, both stages fill and input backs up
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && in_valid && in_ready |=> !in_ready || out_ready)
		else $error("input taken with both stages full");

endmodule

bind quadrature_pitch_tuner_core qpt_checker u_qpt_checker (.*);
`default_nettype wire
